// File: sv/rtch_pkg.sv
`timescale 1ns / 1ps
package rtch_pkg;

	// item kinds carried in s_tuser
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TRI  = 1'b1
	} op_t;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned SW         = COORD_W + 1;   // edge / ray vector width
	localparam int unsigned XW         = 68;            // cross product width
	localparam int unsigned PW         = 104;           // accumulator width
	localparam int unsigned DW         = 31;            // distance width
	localparam int unsigned IW         = 16;            // triangle index width
	localparam int unsigned FRAC       = 16;            // Q16.16 fraction bits
	localparam int unsigned QDEPTH     = 2;
	localparam int unsigned NSTEP      = 24;
	localparam int unsigned STEP_W     = $clog2(NSTEP);
	localparam int unsigned MAX_TRI_DEF = 65536;

	localparam logic [COORD_W-1:0] NO_HIT   = '1;
	localparam logic [DW-1:0]      DIST_MAX = '1;

	// one queue entry, vertices already turned into edges
	typedef struct packed {
		op_t                      kind;
		logic                     last;
		logic [2:0][COORD_W-1:0]  va;
		logic [2:0][SW-1:0]       e1;   // direction on a ray load
		logic [2:0][SW-1:0]       e2;
	} entry_t;

	typedef enum logic [1:0] {
		X_E2 = 2'd0,
		X_PV = 2'd1,
		X_E1 = 2'd2,
		X_QV = 2'd3
	} xsel_t;

	typedef enum logic [1:0] {
		Y_DV = 2'd0,
		Y_E1 = 2'd1,
		Y_TV = 2'd2,
		Y_E2 = 2'd3
	} ysel_t;

	typedef enum logic [3:0] {
		D_NONE = 4'd0,
		D_PV0  = 4'd1,
		D_PV1  = 4'd2,
		D_PV2  = 4'd3,
		D_QV0  = 4'd4,
		D_QV1  = 4'd5,
		D_QV2  = 4'd6,
		D_DET  = 4'd7,
		D_A    = 4'd8,
		D_B    = 4'd9,
		D_N    = 4'd10
	} dst_t;

	// one multiply-accumulate step of the intersection program
	typedef struct packed {
		xsel_t      xsel;
		logic [1:0] xi;
		ysel_t      ysel;
		logic [1:0] yi;
		logic       neg;
		logic       first;
		dst_t       dst;
	} step_t;

	function automatic step_t mk(xsel_t xs, logic [1:0] xi, ysel_t ys, logic [1:0] yi,
			logic ng, logic fs, dst_t ds);
		step_t s;
		s.xsel  = xs;
		s.xi    = xi;
		s.ysel  = ys;
		s.yi    = yi;
		s.neg   = ng;
		s.first = fs;
		s.dst   = ds;
		return s;
	endfunction

	// pv = d x e2, det = e1.pv, qv = tv x e1, a = tv.pv, b = d.qv, n = e2.qv
	function automatic step_t step_of(logic [STEP_W-1:0] idx);
		step_t s;
		case (idx)
			5'd0:  s = mk(X_E2, 2'd2, Y_DV, 2'd1, 1'b0, 1'b1, D_NONE);
			5'd1:  s = mk(X_E2, 2'd1, Y_DV, 2'd2, 1'b1, 1'b0, D_PV0);
			5'd2:  s = mk(X_E2, 2'd0, Y_DV, 2'd2, 1'b0, 1'b1, D_NONE);
			5'd3:  s = mk(X_E2, 2'd2, Y_DV, 2'd0, 1'b1, 1'b0, D_PV1);
			5'd4:  s = mk(X_E2, 2'd1, Y_DV, 2'd0, 1'b0, 1'b1, D_NONE);
			5'd5:  s = mk(X_E2, 2'd0, Y_DV, 2'd1, 1'b1, 1'b0, D_PV2);
			5'd6:  s = mk(X_PV, 2'd0, Y_E1, 2'd0, 1'b0, 1'b1, D_NONE);
			5'd7:  s = mk(X_PV, 2'd1, Y_E1, 2'd1, 1'b0, 1'b0, D_NONE);
			5'd8:  s = mk(X_PV, 2'd2, Y_E1, 2'd2, 1'b0, 1'b0, D_DET);
			5'd9:  s = mk(X_E1, 2'd2, Y_TV, 2'd1, 1'b0, 1'b1, D_NONE);
			5'd10: s = mk(X_E1, 2'd1, Y_TV, 2'd2, 1'b1, 1'b0, D_QV0);
			5'd11: s = mk(X_E1, 2'd0, Y_TV, 2'd2, 1'b0, 1'b1, D_NONE);
			5'd12: s = mk(X_E1, 2'd2, Y_TV, 2'd0, 1'b1, 1'b0, D_QV1);
			5'd13: s = mk(X_E1, 2'd1, Y_TV, 2'd0, 1'b0, 1'b1, D_NONE);
			5'd14: s = mk(X_E1, 2'd0, Y_TV, 2'd1, 1'b1, 1'b0, D_QV2);
			5'd15: s = mk(X_PV, 2'd0, Y_TV, 2'd0, 1'b0, 1'b1, D_NONE);
			5'd16: s = mk(X_PV, 2'd1, Y_TV, 2'd1, 1'b0, 1'b0, D_NONE);
			5'd17: s = mk(X_PV, 2'd2, Y_TV, 2'd2, 1'b0, 1'b0, D_A);
			5'd18: s = mk(X_QV, 2'd0, Y_DV, 2'd0, 1'b0, 1'b1, D_NONE);
			5'd19: s = mk(X_QV, 2'd1, Y_DV, 2'd1, 1'b0, 1'b0, D_NONE);
			5'd20: s = mk(X_QV, 2'd2, Y_DV, 2'd2, 1'b0, 1'b0, D_B);
			5'd21: s = mk(X_QV, 2'd0, Y_E2, 2'd0, 1'b0, 1'b1, D_NONE);
			5'd22: s = mk(X_QV, 2'd1, Y_E2, 2'd1, 1'b0, 1'b0, D_NONE);
			5'd23: s = mk(X_QV, 2'd2, Y_E2, 2'd2, 1'b0, 1'b0, D_N);
			default: s = mk(X_E2, 2'd0, Y_DV, 2'd0, 1'b0, 1'b1, D_NONE);
		endcase
		return s;
	endfunction

endpackage

// File: sv/rtch_front.sv
`timescale 1ns / 1ps
module rtch_front (
	input  logic                       tvalid,
	output logic                       tready,
	input  logic [9*rtch_pkg::COORD_W-1:0] tdata,
	input  logic                       tuser,
	input  logic                       tlast,
	input  logic                       q_full,
	output logic                       push,
	output rtch_pkg::entry_t           entry
);

	logic [2:0][rtch_pkg::COORD_W-1:0] va, vb, vc;

	// unpack the three vertices
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			va[k] = tdata[k*rtch_pkg::COORD_W +: rtch_pkg::COORD_W];
			vb[k] = tdata[(3+k)*rtch_pkg::COORD_W +: rtch_pkg::COORD_W];
			vc[k] = tdata[(6+k)*rtch_pkg::COORD_W +: rtch_pkg::COORD_W];
		end
	end

	// classify and form the edges; a load keeps the direction in e1
	always_comb begin
		entry.kind = rtch_pkg::op_t'(tuser);
		entry.last = tlast;
		entry.va   = va;
		for (int k = 0; k < 3; k++) begin
			if (entry.kind == rtch_pkg::OP_LOAD) begin
				entry.e1[k] = {vb[k][rtch_pkg::COORD_W-1], vb[k]};
				entry.e2[k] = '0;
			end else begin
				entry.e1[k] = {vb[k][rtch_pkg::COORD_W-1], vb[k]}
					- {va[k][rtch_pkg::COORD_W-1], va[k]};
				entry.e2[k] = {vc[k][rtch_pkg::COORD_W-1], vc[k]}
					- {va[k][rtch_pkg::COORD_W-1], va[k]};
			end
		end
	end

	assign tready = !q_full;
	assign push   = tvalid && !q_full;

endmodule

// File: sv/rtch_queue.sv
`timescale 1ns / 1ps
module rtch_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rtch_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output rtch_pkg::entry_t rd_entry
);

	localparam int unsigned AW = $clog2(rtch_pkg::QDEPTH);

	rtch_pkg::entry_t    slot_q [rtch_pkg::QDEPTH];
	logic [AW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [AW:0]         count_q;

	assign full      = count_q == (AW+1)'(rtch_pkg::QDEPTH);
	assign not_empty = count_q != '0;
	assign rd_entry  = slot_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(rtch_pkg::QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(rtch_pkg::QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_entry;
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> not_empty) else $error("queue lost an entry");

endmodule

// File: sv/rtch_mul.sv
`timescale 1ns / 1ps
module rtch_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [rtch_pkg::XW-1:0]    x,
	input  logic signed [rtch_pkg::SW-1:0]    y,
	input  logic                              neg,
	output logic                              busy,
	output logic                              done,
	output logic signed [rtch_pkg::PW-1:0]    p
);

	localparam int unsigned CW = $clog2(rtch_pkg::SW + 1);

	logic                          busy_q, done_q, neg_q;
	logic [CW-1:0]                 cnt_q;
	logic [rtch_pkg::PW-1:0]       mcand_q, acc_q;
	logic [rtch_pkg::SW-1:0]       ymag_q;

	assign busy = busy_q;
	assign done = done_q;
	assign p    = neg_q ? -$signed(acc_q) : $signed(acc_q);

	// shift-add control, one multiplier bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(rtch_pkg::SW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial sum datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= {{(rtch_pkg::PW-rtch_pkg::XW){x[rtch_pkg::XW-1]}}, x};
			ymag_q  <= y[rtch_pkg::SW-1] ? -y : y;
			neg_q   <= y[rtch_pkg::SW-1] ^ neg;
			acc_q   <= '0;
		end else if (busy_q) begin
			if (ymag_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q << 1;
			ymag_q  <= ymag_q >> 1;
		end
	end

endmodule

// File: sv/rtch_back.sv
`timescale 1ns / 1ps
module rtch_back #(
	parameter int unsigned MAX_TRIANGLES = rtch_pkg::MAX_TRI_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  rtch_pkg::entry_t             q_entry,
	output logic                         pop,
	output logic                         m_valid,
	input  logic                         m_ready,
	output logic                         m_hit,
	output logic [rtch_pkg::DW-1:0]      m_distance,
	output logic [rtch_pkg::IW-1:0]      m_index
);

	localparam int unsigned PW = rtch_pkg::PW;
	localparam int unsigned XW = rtch_pkg::XW;
	localparam int unsigned SW = rtch_pkg::SW;
	localparam int unsigned DW = rtch_pkg::DW;
	localparam int unsigned IW = rtch_pkg::IW;
	localparam int unsigned DCW = $clog2(DW);

	typedef enum logic [3:0] {
		S_IDLE, S_MSTART, S_MWAIT, S_SIGN, S_TEST, S_DIV, S_UPD, S_EMIT
	} state_t;

	state_t                            state_q;
	logic [rtch_pkg::STEP_W-1:0]       step_q;
	logic                              last_q;
	logic [2:0][rtch_pkg::COORD_W-1:0] org_q, dir_q;
	logic signed [SW-1:0]              dv_q [3];
	logic signed [SW-1:0]              tv_q [3];
	logic signed [SW-1:0]              e1_q [3];
	logic signed [SW-1:0]              e2_q [3];
	logic signed [XW-1:0]              pv_q [3];
	logic signed [XW-1:0]              qv_q [3];
	logic signed [PW-1:0]              acc_q, det_q, a_q, b_q, n_q;
	logic [PW-1:0]                     rem_q;
	logic [DW-1:0]                     nsh_q, quo_q, dist_q;
	logic [DCW-1:0]                    dcnt_q;
	logic [rtch_pkg::COORD_W-1:0]      best_q;
	logic [IW-1:0]                     bidx_q, count_q;
	logic                              m_valid_q, m_hit_q;
	logic [DW-1:0]                     m_dist_q;
	logic [IW-1:0]                     m_idx_q;

	rtch_pkg::step_t                   st;
	logic signed [XW-1:0]              xop;
	logic signed [SW-1:0]              yop;
	logic                              mul_start, mul_busy, mul_done;
	logic signed [PW-1:0]              prod, acc_next, slack;
	logic [PW-1:0]                     trial;
	logic                              trial_ge, out_free;

	assign st        = rtch_pkg::step_of(step_q);
	assign mul_start = state_q == S_MSTART;
	assign pop       = state_q == S_IDLE && q_valid;
	assign out_free  = !m_valid_q || m_ready;

	// select multiplier operands for the current step
	always_comb begin
		case (st.xsel)
			rtch_pkg::X_E2: xop = {{(XW-SW){e2_q[st.xi][SW-1]}}, e2_q[st.xi]};
			rtch_pkg::X_PV: xop = pv_q[st.xi];
			rtch_pkg::X_E1: xop = {{(XW-SW){e1_q[st.xi][SW-1]}}, e1_q[st.xi]};
			rtch_pkg::X_QV: xop = qv_q[st.xi];
			default:        xop = '0;
		endcase
		case (st.ysel)
			rtch_pkg::Y_DV: yop = dv_q[st.yi];
			rtch_pkg::Y_E1: yop = e1_q[st.yi];
			rtch_pkg::Y_TV: yop = tv_q[st.yi];
			rtch_pkg::Y_E2: yop = e2_q[st.yi];
			default:        yop = '0;
		endcase
	end

	rtch_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (xop),
		.y      (yop),
		.neg    (st.neg),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (prod)
	);

	assign acc_next = st.first ? prod : acc_q + prod;
	assign slack    = det_q - a_q - b_q;
	assign trial    = {rem_q[PW-2:0], nsh_q[DW-1]};
	assign trial_ge = trial >= $unsigned(det_q);

	// sequencer state, ray, batch state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			dcnt_q    <= '0;
			org_q     <= '0;
			dir_q     <= '0;
			best_q    <= rtch_pkg::NO_HIT;
			bidx_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
			m_hit_q   <= 1'b0;
			m_dist_q  <= '0;
			m_idx_q   <= '0;
		end else begin
			if (m_valid_q && m_ready && state_q != S_EMIT) m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_entry.kind == rtch_pkg::OP_LOAD) begin
							org_q   <= q_entry.va;
							for (int k = 0; k < 3; k++) dir_q[k] <= q_entry.e1[k][SW-2:0];
							best_q  <= rtch_pkg::NO_HIT;
							bidx_q  <= '0;
							count_q <= '0;
						end else begin
							step_q  <= '0;
							state_q <= S_MSTART;
						end
					end
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_done) begin
						if (step_q == rtch_pkg::STEP_W'(rtch_pkg::NSTEP-1)) begin
							state_q <= S_SIGN;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= S_MSTART;
						end
					end
				end
				S_SIGN: state_q <= (det_q == '0) ? S_UPD : S_TEST;
				S_TEST: begin
					dcnt_q <= '0;
					if (a_q < 0 || b_q < 0 || slack < 0 || n_q <= 0) begin
						state_q <= S_UPD;
					end else if ((n_q >>> (DW - rtch_pkg::FRAC)) >= det_q) begin
						state_q <= S_UPD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCW'(DW-1)) state_q <= S_UPD;
				end
				S_UPD: begin
					if (dist_q != '0 && {1'b0, dist_q} < best_q) begin
						best_q <= {1'b0, dist_q};
						bidx_q <= count_q;
					end
					count_q <= ({1'b0, count_q} == (IW+1)'(MAX_TRIANGLES-1)) ? '0
						: count_q + 1'b1;
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_hit_q   <= best_q != rtch_pkg::NO_HIT;
						m_dist_q  <= best_q[DW-1:0];
						m_idx_q   <= bidx_q;
						best_q    <= rtch_pkg::NO_HIT;
						bidx_q    <= '0;
						count_q   <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// vector registers, sums and the divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					last_q <= q_entry.last;
					if (q_entry.kind != rtch_pkg::OP_LOAD) begin
						for (int k = 0; k < 3; k++) begin
							dv_q[k] <= {dir_q[k][SW-2], dir_q[k]};
							tv_q[k] <= $signed({org_q[k][SW-2], org_q[k]})
								- $signed({q_entry.va[k][SW-2], q_entry.va[k]});
							e1_q[k] <= q_entry.e1[k];
							e2_q[k] <= q_entry.e2[k];
						end
					end
				end
			end
			S_MWAIT: begin
				if (mul_done) begin
					acc_q <= acc_next;
					case (st.dst)
						rtch_pkg::D_PV0: pv_q[0] <= XW'(acc_next);
						rtch_pkg::D_PV1: pv_q[1] <= XW'(acc_next);
						rtch_pkg::D_PV2: pv_q[2] <= XW'(acc_next);
						rtch_pkg::D_QV0: qv_q[0] <= XW'(acc_next);
						rtch_pkg::D_QV1: qv_q[1] <= XW'(acc_next);
						rtch_pkg::D_QV2: qv_q[2] <= XW'(acc_next);
						rtch_pkg::D_DET: det_q   <= acc_next;
						rtch_pkg::D_A:   a_q     <= acc_next;
						rtch_pkg::D_B:   b_q     <= acc_next;
						rtch_pkg::D_N:   n_q     <= acc_next;
						default: ;
					endcase
				end
			end
			S_SIGN: begin
				dist_q <= '0;
				if (det_q < 0) begin
					det_q <= -det_q;
					a_q   <= -a_q;
					b_q   <= -b_q;
					n_q   <= -n_q;
				end
			end
			S_TEST: begin
				rem_q <= $unsigned(n_q >>> (DW - rtch_pkg::FRAC));
				nsh_q <= {n_q[DW-rtch_pkg::FRAC-1:0], {rtch_pkg::FRAC{1'b0}}};
				quo_q <= '0;
				if (a_q < 0 || b_q < 0 || slack < 0 || n_q <= 0) begin
					dist_q <= '0;
				end else if ((n_q >>> (DW - rtch_pkg::FRAC)) >= det_q) begin
					dist_q <= rtch_pkg::DIST_MAX;
				end
			end
			S_DIV: begin
				rem_q  <= trial_ge ? trial - $unsigned(det_q) : trial;
				nsh_q  <= nsh_q << 1;
				quo_q  <= {quo_q[DW-2:0], trial_ge};
				dist_q <= {quo_q[DW-2:0], trial_ge};
			end
			default: ;
		endcase
	end

	assign m_valid    = m_valid_q;
	assign m_hit      = m_hit_q;
	assign m_distance = m_dist_q;
	assign m_index    = m_idx_q;

	a_nohit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(best_q == rtch_pkg::NO_HIT) |-> (bidx_q == '0))
		else $error("index kept without a hit");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy) else $error("multiplier restarted while busy");
	a_div_det: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (det_q > 0)) else $error("divide by non-positive det");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !out_free) |=> (state_q == S_EMIT))
		else $error("result dropped while output full");

endmodule

// File: sv/ray_triangle_closest_hit.sv
`timescale 1ns / 1ps
// channel  dir  tdata                                   tuser       tlast
// s_*      in   vertex a xyz, b xyz, c xyz (9 x 32)     opcode      last_triangle
// m_*      out  distance(31), triangle_index(16), pad   hit         -
//
// A ray load is taken into the queue and then popped by the back end.
// A triangle is popped, runs its intersection steps in the shared shift-add
// multiplier, then sign, test and update, the divider when the test passes and
// an emit on the last triangle of a batch.
// arst_n clears the ray to zero and the running best to no hit.
// A two-entry queue lets the input accept items while the back end works;
// a waiting result holds the back end in its next emit until m_tready, and the input once the queue is full.
module ray_triangle_closest_hit #(
	parameter int unsigned MAX_TRIANGLES = rtch_pkg::MAX_TRI_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,   // vertex_a_x,y,z, vertex_b_x,y,z, vertex_c_x,y,z
	input  logic         s_tuser,   // opcode
	input  logic         s_tlast,   // last_triangle
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,   // distance, triangle_index, zero pad
	output logic         m_tuser    // hit
);

	logic             q_full, q_push, q_valid, q_pop;
	rtch_pkg::entry_t wr_entry, rd_entry;
	logic [rtch_pkg::DW-1:0] distance;
	logic [rtch_pkg::IW-1:0] triangle_index;

	rtch_front u_front (
		.tvalid (s_tvalid),
		.tready (s_tready),
		.tdata  (s_tdata),
		.tuser  (s_tuser),
		.tlast  (s_tlast),
		.q_full (q_full),
		.push   (q_push),
		.entry  (wr_entry)
	);

	rtch_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (wr_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_entry  (rd_entry)
	);

	rtch_back #(
		.MAX_TRIANGLES (MAX_TRIANGLES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_entry    (rd_entry),
		.pop        (q_pop),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.m_hit      (m_tuser),
		.m_distance (distance),
		.m_index    (triangle_index)
	);

	assign m_tdata = {1'b0, triangle_index, distance};

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam logic [31:0] ONE       = 32'h0001_0000;
	localparam int          LIMIT     = 10_000_000;
	localparam int          HOLD_LEN  = 6000;
	localparam int          TAIL_WAIT = 1100;
	localparam int          N_RANDOM  = 1200;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		rtch_pkg::op_t    op;
		logic [8:0][31:0] v;     // a xyz, b xyz, c xyz
		logic             last;
	} tri_item_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] t_dist;
		logic [15:0] idx;
	} hit_result_t;

	typedef struct packed {
		tri_item_t   it;
		logic        typed;
		hit_result_t res;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic         m_tuser;

	ray_triangle_closest_hit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	logic signed [31:0] ray_org [3];
	logic signed [31:0] ray_dir [3];
	logic [31:0]        best_dist;
	logic [15:0]        best_idx;
	logic [15:0]        tri_count;

	hit_result_t nearest_hits [$];
	tri_item_t   cur_item;
	logic        cur_typed;
	hit_result_t cur_res;
	logic        in_fire;
	int          errors;
	int          cycles;
	logic        long_hold_req;
	logic        no_idle;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// wide-arithmetic plane distance in Q16.16, truncated, DIST_MAX on overflow, 0 on a miss
	function automatic logic [31:0] hit_distance(tri_item_t it);
		wide_t va[3], e1[3], e2[3], tv[3], dv[3], pv[3], qv[3];
		wide_t det, wa, wb, wn, quo;
		int k;
		for (k = 0; k < 3; k++) begin
			va[k] = $signed(it.v[k]);
			e1[k] = $signed(it.v[3+k]) - va[k];
			e2[k] = $signed(it.v[6+k]) - va[k];
			tv[k] = ray_org[k] - va[k];
			dv[k] = ray_dir[k];
		end
		pv[0] = dv[1] * e2[2] - dv[2] * e2[1];
		pv[1] = dv[2] * e2[0] - dv[0] * e2[2];
		pv[2] = dv[0] * e2[1] - dv[1] * e2[0];
		det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
		if (det == 0)
			return 32'd0;
		qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
		qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
		qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
		wa = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
		wb = dv[0] * qv[0] + dv[1] * qv[1] + dv[2] * qv[2];
		wn = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
		if (det < 0) begin
			det = -det; wa = -wa; wb = -wb; wn = -wn;
		end
		if (wa < 0 || wb < 0 || det - wa - wb < 0 || wn <= 0)
			return 32'd0;
		quo = (wn <<< 16) / det;
		if (quo > 128'sd2147483647)
			return {1'b0, rtch_pkg::DIST_MAX};
		return quo[31:0];
	endfunction

	// advance the predictor by one accepted item; returns 1 when a result is due
	function automatic logic predict_closest(tri_item_t it, output hit_result_t r);
		logic [31:0] d;
		int k;
		r = '0;
		if (it.op == rtch_pkg::OP_LOAD) begin
			for (k = 0; k < 3; k++) begin
				ray_org[k] = it.v[k];
				ray_dir[k] = it.v[3+k];
			end
			best_dist = rtch_pkg::NO_HIT; best_idx = '0; tri_count = '0;
			return 1'b0;
		end
		d = hit_distance(it);
		if (d != 0 && d < best_dist) begin
			best_dist = d;
			best_idx  = tri_count;
		end
		tri_count = tri_count + 16'd1;
		if (!it.last)
			return 1'b0;
		r.hit    = (best_dist != rtch_pkg::NO_HIT);
		r.t_dist = r.hit ? best_dist[30:0] : rtch_pkg::DIST_MAX;
		r.idx    = r.hit ? best_idx : 16'd0;
		best_dist = rtch_pkg::NO_HIT; best_idx = '0; tri_count = '0;
		return 1'b1;
	endfunction

	// log input transfers and check output transfers
	always @(posedge clk or negedge arst_n) begin
		hit_result_t r, want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				if (predict_closest(cur_item, r))
					nearest_hits.push_back(cur_typed ? cur_res : r);
			end
			if (m_tvalid && m_tready) begin
				if (nearest_hits.size() == 0) begin
					errors++;
					$display("%0t: unexpected result hit=%0b dist=%h idx=%0d", $time,
						m_tuser, m_tdata[30:0], m_tdata[46:31]);
				end else begin
					want = nearest_hits.pop_front();
					if (m_tuser !== want.hit || m_tdata[30:0] !== want.t_dist
							|| m_tdata[46:31] !== want.idx) begin
						errors++;
						$display("%0t: expected hit=%0b dist=%h idx=%0d, got hit=%0b dist=%h idx=%0d",
							$time, want.hit, want.t_dist, want.idx,
							m_tuser, m_tdata[30:0], m_tdata[46:31]);
					end
				end
			end
		end
	end

	// hard stop
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(3, 1);
		if (r < 98) return $urandom_range(20, 4);
		return $urandom_range(300, 50);
	endfunction

	// output side: random back-pressure, one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				long_hold_req = 1'b0;
			end else begin
				int len;
				len = pick_gap();
				if (len == 0) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(40, 1)) @(negedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat (len) @(negedge clk);
				end
			end
		end
	end

	task automatic send(tri_item_t it, logic typed, hit_result_t res);
		int gap;
		cur_item  <= it;
		cur_typed <= typed;
		cur_res   <= res;
		s_tdata   <= it.v;
		s_tuser   <= it.op;
		s_tlast   <= it.last;
		s_tvalid  <= 1'b1;
		do @(negedge clk); while (!in_fire);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic tri_item_t mk_item(rtch_pkg::op_t op, logic [31:0] ax, ay, az,
			bx, by, bz, cx, cy, cz, logic last);
		tri_item_t it;
		it.op   = op;
		it.v    = {cz, cy, cx, bz, by, bx, az, ay, ax};
		it.last = last;
		return it;
	endfunction

	function automatic logic [31:0] jitter(logic [31:0] base, int span);
		return base + $signed($urandom_range(2 * span)) - span;
	endfunction

	stim_row_t   rows [$];
	tri_item_t   prev_tri;
	hit_result_t none_res;
	hit_result_t miss_res;

	initial begin
		int sent, n_tri, t, kind, mult;
		logic [31:0] ox, oy, oz, dx, dy, dz, px, py, pz;
		tri_item_t it;
		errors = 0; cycles = 0;
		long_hold_req = 1'b0; no_idle = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0;
		cur_item = '0; cur_typed = 1'b0; cur_res = '0;
		foreach (ray_org[k]) begin
			ray_org[k] = '0;
			ray_dir[k] = '0;
		end
		best_dist = rtch_pkg::NO_HIT; best_idx = '0; tri_count = '0;
		none_res = '0;
		miss_res = '{hit: 1'b0, t_dist: rtch_pkg::DIST_MAX, idx: 16'd0};
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, -ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE,
			0, ONE, 2*ONE, 1), 1, miss_res});                   // no ray loaded yet
		rows.push_back('{mk_item(rtch_pkg::OP_LOAD, 0, 0, 0, 0, 0, ONE, '1, '1, '1, 1),
			0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, -ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE,
			0, ONE, 2*ONE, 0), 0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, -ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE,
			0, ONE, 2*ONE, 0), 0, none_res});                   // tie, earlier wins
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, ONE, -ONE, 0, ONE, ONE, 0, ONE, 0, 2*ONE, 0),
			0, none_res});                                       // parallel
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0),
			0, none_res});                                       // degenerate
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, 0, -ONE, ONE, 0, ONE, ONE, 2*ONE, 0, ONE, 1),
			1, '{1'b1, 31'h0001_0000, 16'd4}});                  // ray grazes an edge
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, -ONE, -ONE, -2*ONE, ONE, -ONE, -2*ONE,
			0, ONE, -2*ONE, 1), 1, miss_res});                   // behind origin
		rows.push_back('{mk_item(rtch_pkg::OP_LOAD, 0, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 0),
			0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, -ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1, 1),
			1, miss_res});                                       // truncates to zero
		rows.push_back('{mk_item(rtch_pkg::OP_LOAD, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, -ONE, -ONE, 32'h4000_0000, ONE, -ONE,
			32'h4000_0000, 0, ONE, 32'h4000_0000, 1), 1,
			'{1'b1, rtch_pkg::DIST_MAX, 16'd0}});                 // saturates
		rows.push_back('{mk_item(rtch_pkg::OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0), 0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 0), 0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, '1, '1, '1, 32'h8000_0000, 0, 32'h7FFF_FFFF,
			0, 32'h8000_0000, '1, 1), 0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_LOAD, 0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0),
			0, none_res});
		rows.push_back('{mk_item(rtch_pkg::OP_TRI, 3*ONE, 0, 0, 0, 3*ONE, 0, 0, 0, 3*ONE, 1),
			0, none_res});
		foreach (rows[i])
			send(rows[i].it, rows[i].typed, rows[i].res);

		// drain completely before the random part
		s_tvalid <= 1'b0;
		wait (nearest_hits.size() == 0);
		repeat (TAIL_WAIT) @(negedge clk);

		sent = 0;
		prev_tri = rows[3].it;
		while (sent < N_RANDOM) begin
			// one long output stall with a burst of one-triangle batches
			if (sent >= N_RANDOM / 2 && sent < N_RANDOM / 2 + 8) begin
				long_hold_req = 1'b1;
				for (t = 0; t < 8; t++) begin
					it = mk_item(rtch_pkg::OP_TRI, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom, $urandom, 1);
					send(it, 0, none_res);
				end
				sent += 8;
				continue;
			end
			no_idle = ($urandom_range(9) == 0);
			kind = $urandom_range(99);
			if (kind < 4) begin
				// stray load with the last flag and random content
				send(mk_item(rtch_pkg::OP_LOAD, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, 1), 0, none_res);
				sent++;
			end
			ox = jitter(0, 1 << 20); oy = jitter(0, 1 << 20); oz = jitter(0, 1 << 20);
			dx = jitter(0, 1 << 18); dy = jitter(0, 1 << 18); dz = jitter(0, 1 << 18);
			if (kind < 10)
				send(mk_item(rtch_pkg::OP_LOAD, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(1)),
					0, none_res);
			else if (kind < 90)
				send(mk_item(rtch_pkg::OP_LOAD, ox, oy, oz, dx, dy, dz, $urandom, $urandom,
					$urandom, $urandom_range(1)), 0, none_res);
			sent++;
			n_tri = $urandom_range(6, 1);
			for (t = 0; t < n_tri; t++) begin
				kind = $urandom_range(99);
				mult = $urandom_range(4, 1);
				px = ox + dx * mult; py = oy + dy * mult; pz = oz + dz * mult;
				if (kind < 60)
					it = mk_item(rtch_pkg::OP_TRI, jitter(px, 1 << 18), jitter(py, 1 << 18),
						jitter(pz, 1 << 18), jitter(px, 1 << 18), jitter(py, 1 << 18),
						jitter(pz, 1 << 18), jitter(px, 1 << 18), jitter(py, 1 << 18),
						jitter(pz, 1 << 18), 0);
				else if (kind < 75)
					it = mk_item(rtch_pkg::OP_TRI, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom, $urandom, 0);
				else if (kind < 85)
					it = prev_tri;
				else
					it = mk_item(rtch_pkg::OP_TRI, jitter(0, 1 << 21), jitter(0, 1 << 21),
						jitter(0, 1 << 21), jitter(0, 1 << 21), jitter(0, 1 << 21),
						jitter(0, 1 << 21), jitter(0, 1 << 21), jitter(0, 1 << 21),
						jitter(0, 1 << 21), 0);
				it.op   = rtch_pkg::OP_TRI;
				it.last = (t == n_tri - 1);
				prev_tri = it;
				send(it, 0, none_res);
				sent++;
			end
		end

		s_tvalid <= 1'b0;
		wait (nearest_hits.size() == 0);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
